/* sv/bitmap_first_fit_block_allocator_core_macros.svh */
// Assertion macros for the block allocator checker.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define BFFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bffa check failed");

// Next-cycle implication.
`define BFFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bffa check failed");

`endif

/* sv/bffa_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps
package bffa_pkg;
  localparam int MaxBlocks = 1024;
  localparam int PosW = $clog2(MaxBlocks);
  localparam int CntW = PosW + 1;
  localparam logic [PosW-1:0] LastPos = PosW'(MaxBlocks - 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBlocks);

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_BODY = 2'd1,
    MARK_HEAD = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2,
    ST_ZERO    = 2'd3
  } status_e;
endpackage

/* sv/bffa_cell.sv */
// One cell of the rotating mark ring: holds one block's 2-bit mark.
// Depends on bffa_pkg.
`timescale 1ns / 1ps
module bffa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  bffa_pkg::mark_e mark_i,
  output bffa_pkg::mark_e mark_o
);
  import bffa_pkg::*;

  mark_e mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= MARK_FREE;
    end else if (shift_i) begin
      mark_q <= mark_i;
    end
  end

  assign mark_o = mark_q;
endmodule

/* sv/bitmap_first_fit_block_allocator_core.sv */
// First-fit contiguous block allocator over a ring of mark cells.
// Allocate runs a find pass then a mark pass, or only the find pass when no run fits;
// free runs one pass; a rejected request goes straight to the result state.
// Throughput: one item at a time, the next accepted once the result registers; each
// pass is one ring revolution, and a busy output register adds stalls.
// Reset: asynchronous, all blocks free, used count zero, total 1024; no clearing pass.
`timescale 1ns / 1ps
module bitmap_first_fit_block_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,      // total_blocks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [10:0] block_count, [20:11] block_index
  input  logic        s_axis_tuser,    // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata     // [1:0] status, [11:2] start_block,
                                       // [22:12] used_count, [33:23] free_count
);
  import bffa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] total_q;
  logic [CntW-1:0] used_q, used_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] run_q, run_d;
  logic            found_q, found_d;
  logic            clr_q, clr_d;
  logic            ok_q, ok_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] idx_q, idx_d;
  logic [PosW-1:0] start_q, start_d;
  status_e         stat_q, stat_d;
  logic            out_valid_q;
  logic [39:0]     out_data_q;

  logic [CntW-1:0] teff;
  logic [CntW-1:0] pos_ext;
  logic [CntW-1:0] run_end;
  logic [CntW:0]   need;
  logic            shift;
  logic            last;
  mark_e           ring [MaxBlocks];
  mark_e           head_mark;
  mark_e           wr_mark;
  logic [CntW-1:0] free_cnt;

  assign teff     = (total_q > MaxCnt) ? MaxCnt : total_q;
  assign pos_ext  = {1'b0, pos_q};
  assign run_end  = {1'b0, start_q} + cnt_q;
  assign need     = {1'b0, used_q} + {1'b0, s_axis_tdata[10:0]};
  assign shift    = (state_q == S_FIND) || (state_q == S_MARK) || (state_q == S_FREE);
  assign last     = (pos_q == LastPos);
  assign head_mark = ring[0];
  assign free_cnt = (teff > used_q) ? teff - used_q : '0;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  genvar k;
  generate
    for (k = 0; k < MaxBlocks; k++) begin : g_cell
      if (k == MaxBlocks - 1) begin : g_tail
        bffa_cell u_cell (.clk_i, .rst_ni, .shift_i(shift), .mark_i(wr_mark),
                          .mark_o(ring[k]));
      end else begin : g_mid
        bffa_cell u_cell (.clk_i, .rst_ni, .shift_i(shift), .mark_i(ring[k+1]),
                          .mark_o(ring[k]));
      end
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    pos_d   = pos_q;
    run_d   = run_q;
    found_d = found_q;
    clr_d   = clr_q;
    ok_d    = ok_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    start_d = start_q;
    stat_d  = stat_q;
    wr_mark = head_mark;
    if (shift) begin
      pos_d = pos_q + 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d   = s_axis_tdata[10:0];
          idx_d   = s_axis_tdata[20:11];
          start_d = '0;
          pos_d   = '0;
          run_d   = '0;
          found_d = 1'b0;
          clr_d   = 1'b0;
          ok_d    = 1'b0;
          if (!s_axis_tuser) begin
            if (s_axis_tdata[10:0] == '0) begin
              stat_d  = ST_ZERO;
              state_d = S_RES;
            end else if (need > {1'b0, teff}) begin
              stat_d  = ST_NOSPACE;
              state_d = S_RES;
            end else begin
              state_d = S_FIND;
            end
          end else if ({1'b0, s_axis_tdata[20:11]} >= teff) begin
            stat_d  = ST_BADFREE;
            state_d = S_RES;
          end else begin
            state_d = S_FREE;
          end
        end
      end
      S_FIND: begin
        if (!found_q && (pos_ext < teff)) begin
          run_d = (head_mark == MARK_FREE) ? run_q + 1'b1 : '0;
          if (run_d == cnt_q) begin
            found_d = 1'b1;
            start_d = PosW'(pos_ext + 1'b1 - cnt_q);
          end
        end
        if (last) begin
          if (found_d) begin
            state_d = S_MARK;
          end else begin
            stat_d  = ST_NOSPACE;
            start_d = '0;
            state_d = S_RES;
          end
        end
      end
      S_MARK: begin
        if (pos_q == start_q) begin
          wr_mark = MARK_HEAD;
        end else if ((pos_q > start_q) && (pos_ext < run_end)) begin
          wr_mark = MARK_BODY;
        end
        if (last) begin
          used_d  = used_q + cnt_q;
          stat_d  = ST_OK;
          state_d = S_RES;
        end
      end
      S_FREE: begin
        if (pos_q == idx_q) begin
          if (head_mark == MARK_HEAD) begin
            wr_mark = MARK_FREE;
            ok_d    = 1'b1;
            clr_d   = 1'b1;
            used_d  = used_q - CntW'(used_q != '0);
          end
        end else if (clr_q) begin
          if (head_mark == MARK_BODY) begin
            wr_mark = MARK_FREE;
            used_d  = used_q - CntW'(used_q != '0);
          end else begin
            clr_d = 1'b0;
          end
        end
        if (last) begin
          stat_d  = ok_d ? ST_OK : ST_BADFREE;
          state_d = S_RES;
        end
      end
      S_RES: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= MaxCnt;
      used_q      <= '0;
      pos_q       <= '0;
      run_q       <= '0;
      found_q     <= 1'b0;
      clr_q       <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      found_q <= found_d;
      clr_q   <= clr_d;
      ok_q    <= ok_d;
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if ((state_q == S_RES) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    start_q <= start_d;
    stat_q  <= stat_d;
    if ((state_q == S_RES) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {6'd0, free_cnt, used_q,
                     (stat_q == ST_OK) ? start_q : {PosW{1'b0}}, stat_q};
    end
  end
endmodule

/* sv/bffa_checker.sv */
// Port-level checks for the block allocator, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "bitmap_first_fit_block_allocator_core_macros.svh"
module bffa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  `BFFA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BFFA_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BFFA_ASSERT_IMP(a_used_range, m_axis_tvalid, m_axis_tdata[22:12] <= 11'd1024)
  `BFFA_ASSERT_IMP(a_start_zero, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0),
                   m_axis_tdata[11:2] == 10'd0)
endmodule

bind bitmap_first_fit_block_allocator_core bffa_checker u_bffa_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* tb/sv/tb.sv */
// Testbench for the first-fit block allocator core: directed table, then random
// alloc/free traffic across several totals, checked against an internal predictor.
// Depends on bffa_pkg and bitmap_first_fit_block_allocator_core.
`timescale 1ns / 1ps
module tb;
  import bffa_pkg::*;

  typedef struct packed {
    status_e     st;
    logic [9:0]  start;
    logic [10:0] used;
    logic [10:0] free;
  } alloc_res_t;

  typedef struct {
    logic        mode;
    logic [10:0] count;
    logic [9:0]  idx;
    logic        typed;
    alloc_res_t  res;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  bitmap_first_fit_block_allocator_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  mark_e       marks[MaxBlocks];
  int          used_blocks;
  int          total_cfg;
  alloc_res_t  pending_results[$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  bit          held = 1'b0;

  function automatic int eff_total();
    return total_cfg > MaxBlocks ? MaxBlocks : total_cfg;
  endfunction

  // Apply one request to the mark map and return the expected result.
  function automatic alloc_res_t allocator_apply(logic mode, int n, int idx);
    alloc_res_t r;
    int t, run, s;
    t = eff_total();
    run = 0;
    r = '0;
    r.st = ST_OK;
    if (mode == 1'b0) begin
      if (n == 0) r.st = ST_ZERO;
      else if (used_blocks + n > t) r.st = ST_NOSPACE;
      else begin
        r.st = ST_NOSPACE;
        for (int i = 0; i < t; i++) begin
          run = (marks[i] == MARK_FREE) ? run + 1 : 0;
          if (run == n) begin
            s = i + 1 - n;
            marks[s] = MARK_HEAD;
            for (int k = s + 1; k <= i; k++) marks[k] = MARK_BODY;
            used_blocks += n;
            r.st = ST_OK;
            r.start = s[9:0];
            break;
          end
        end
      end
    end else begin
      if (idx >= t || marks[idx] != MARK_HEAD) r.st = ST_BADFREE;
      else begin
        marks[idx] = MARK_FREE;
        if (used_blocks > 0) used_blocks--;
        for (int i = idx + 1; i < MaxBlocks && marks[i] == MARK_BODY; i++) begin
          marks[i] = MARK_FREE;
          if (used_blocks > 0) used_blocks--;
        end
      end
    end
    r.used = used_blocks[10:0];
    r.free = (t > used_blocks) ? 11'(t - used_blocks) : '0;
    return r;
  endfunction

  task automatic send_request(logic mode, logic [10:0] n, logic [9:0] idx, logic typed,
                              alloc_res_t typed_res);
    alloc_res_t r;
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b0, idx, n};
    do @(posedge clk_i); while (!s_axis_tready);
    r = allocator_apply(mode, int'(n), int'(idx));
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // Let every outstanding result drain, then write the total while idle.
  task automatic write_total(logic [10:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * MaxBlocks + 8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    total_cfg = int'(value);
  endtask

  task automatic random_request();
    int heads[$];
    int t, n, pick;
    t = eff_total();
    for (int i = 0; i < MaxBlocks; i++) if (marks[i] == MARK_HEAD) heads.push_back(i);
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise: free at any index, or odd-sized allocates
      if ($urandom_range(1)) send_request(1'b1, 11'($urandom), 10'($urandom), 1'b0, '0);
      else send_request(1'b0, $urandom_range(2) == 0 ? 11'd0 : 11'($urandom_range(1024)),
                        10'($urandom), 1'b0, '0);
    end else if (heads.size() != 0 &&
                 (pick < 45 || used_blocks * 4 > t * 3)) begin
      send_request(1'b1, 11'($urandom), 10'(heads[$urandom_range(heads.size() - 1)]),
                   1'b0, '0);
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) n = $urandom_range(16, 1);
      else if (pick < 92) n = $urandom_range(200, 17);
      else n = $urandom_range(1024, 1);
      send_request(1'b0, 11'(n), 10'($urandom), 1'b0, '0);
    end
  endtask

  // Result side: random stalls plus one long hold-off early in the run.
  always @(posedge clk_i) begin
    alloc_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.st    = status_e'(m_axis_tdata[1:0]);
      got.start = m_axis_tdata[11:2];
      got.used  = m_axis_tdata[22:12];
      got.free  = m_axis_tdata[33:23];
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.st !== want.st || got.start !== want.start ||
            got.used !== want.used || got.free !== want.free) begin
          $display("%0t: result mismatch, expected %p, actual %p", $realtime, want, got);
          errors++;
        end
      end
    end
    if (results_seen == 20 && !held) begin
      held <= 1'b1;
      hold_left <= 6000;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  req_row_t directed[] = '{
    '{1'b0, 11'd0,    10'd0,    1'b1, '{ST_ZERO,    10'd0, 11'd0,    11'd1024}},
    '{1'b0, 11'd1024, 10'd1023, 1'b1, '{ST_OK,      10'd0, 11'd1024, 11'd0}},
    '{1'b0, 11'd1,    10'd0,    1'b1, '{ST_NOSPACE, 10'd0, 11'd1024, 11'd0}},
    '{1'b1, 11'd2047, 10'd1,    1'b1, '{ST_BADFREE, 10'd0, 11'd1024, 11'd0}},
    '{1'b1, 11'd0,    10'd0,    1'b1, '{ST_OK,      10'd0, 11'd0,    11'd1024}},
    '{1'b1, 11'd0,    10'd0,    1'b1, '{ST_BADFREE, 10'd0, 11'd0,    11'd1024}},
    '{1'b1, 11'd0,    10'd1023, 1'b1, '{ST_BADFREE, 10'd0, 11'd0,    11'd1024}},
    '{1'b0, 11'd3,    10'd0,    1'b0, '0},
    '{1'b0, 11'd5,    10'd0,    1'b0, '0},
    '{1'b0, 11'd1,    10'd0,    1'b0, '0},
    '{1'b1, 11'd0,    10'd0,    1'b0, '0},
    '{1'b0, 11'd2,    10'd0,    1'b0, '0},
    '{1'b0, 11'd2,    10'd0,    1'b0, '0},
    '{1'b1, 11'd0,    10'd3,    1'b0, '0},
    '{1'b0, 11'd6,    10'd0,    1'b0, '0},
    '{1'b0, 11'd1023, 10'd0,    1'b0, '0},
    '{1'b1, 11'd0,    10'd8,    1'b0, '0}
  };

  logic [10:0] totals[7] = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd37, 11'd512, 11'd1024};
  int          idle_mix[4] = '{0, 62, 0, 18};
  int          stall_mix[4] = '{0, 0, 62, 18};

  initial begin
    for (int i = 0; i < MaxBlocks; i++) marks[i] = MARK_FREE;
    used_blocks = 0;
    total_cfg = 1024;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i])
      send_request(directed[i].mode, directed[i].count, directed[i].idx,
                   directed[i].typed, directed[i].res);
    // Totals change with runs still live, so the lowered-total cases come up.
    foreach (totals[p]) begin
      write_total(totals[p]);
      idle_pct  = idle_mix[p % 4];
      stall_pct = stall_mix[p % 4];
      repeat (81) random_request();
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * MaxBlocks + 8) @(posedge clk_i);
    $display("Covered %0d requests, %0d results, totals 0 through 2047 with live runs.",
             items_sent, results_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end
endmodule
